@@ rtl/stis_pkg.sv @@
`timescale 1ns / 1ps

package stis_pkg;

  // Fixed widths of the transaction fields
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 3;

  // Default sizing for the top level
  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic                 kind;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [PAYLOAD_W-1:0] read_payload;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_SHIFT,
    ST_PUT,
    ST_RESP
  } state_t;

endpackage

@@ rtl/sorted_table_insert_search.sv @@
// Sorted key/payload table with insert and binary-search lookup.
// Request channel (req_valid / req_stall / req): one transaction carries
// kind (insert or lookup), key and payload. The block raises req_stall
// while it works on a transaction, so one transaction is in flight.
// Response channel (rsp_valid / rsp_stall / rsp): one response per
// request, in order, with status, found flag and read payload.
// Operation: each binary-search probe is a read of the table memory
// (ST_SEARCH) plus a compare of the read key (ST_CMP); the search ends
// on a key match or when lo reaches hi. A lookup or a rejected insert
// then goes to ST_RESP, which loads the response register. An accepted
// insert first moves the entries above the insert point up one slot per
// cycle in ST_SHIFT (read and write ports of the memory pipelined),
// then writes the new record in ST_PUT. At depth 64 the worst case
// moves 63 entries, so the shift loop sets the worst-case time.
// After the response is loaded the block returns to ST_IDLE, where it
// takes the next request.
// Reset (rst, synchronous) empties the table by clearing the entry
// count; memory contents are not cleared. A stalled response holds in
// the output register and the next request is still taken meanwhile;
// the block only waits if a second result is ready before the first
// one is taken.
`timescale 1ns / 1ps

module sorted_table_insert_search #(
  parameter int TABLE_DEPTH  = stis_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS     = stis_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = stis_pkg::PAYLOAD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  stis_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output stis_pkg::rsp_t rsp
);
  import stis_pkg::*;

  // Effective stored widths: fields are never wider than the port
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int PW = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;   // count, lo, hi can hold TABLE_DEPTH
  localparam int EW = KW + PW;  // memory word: key over payload
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t state, state_next;

  // Table memory, one record per word
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  // Current transaction
  logic          cur_kind;
  logic [KW-1:0] cur_key;
  logic [PW-1:0] cur_payload;

  // Search and shift bookkeeping
  logic [CW-1:0] count;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [AW-1:0] mid;
  logic [CW-1:0] mid_calc;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] move_left;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          pend;
  logic          search_done;

  // Result waiting for the output register
  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [PW-1:0]       res_payload;
  logic [PAYLOAD_W-1:0] res_payload_ext;

  logic [KW-1:0] rd_key;
  logic [PW-1:0] rd_payload;
  logic          out_free;

  assign rd_key      = rdata[EW-1:PW];
  assign rd_payload  = rdata[PW-1:0];
  assign mid_calc    = lo + ((hi - lo) >> 1);
  assign count_m1    = count - 1'b1;
  assign search_done = !(lo < hi);
  assign out_free    = !rsp_valid || !rsp_stall;

  always_comb begin
    res_payload_ext         = '0;
    res_payload_ext[PW-1:0] = res_payload;
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!search_done) begin
          state_next = ST_CMP;
        end else if (cur_kind == KIND_LOOKUP || count == DEPTH_C) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_CMP: begin
        if (cur_key == rd_key) state_next = ST_RESP;
        else                   state_next = ST_SEARCH;
      end
      ST_SHIFT: begin
        // last pending write drains in this cycle
        if (move_left == '0) state_next = ST_PUT;
      end
      ST_PUT: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Outputs: handshake and memory port controls
  // ---------------------------------------------------------------------
  always_comb begin
    req_stall = 1'b1;
    raddr     = rd_addr;
    we        = 1'b0;
    waddr     = wr_addr;
    wdata     = rdata;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
      end
      ST_SEARCH: begin
        raddr = mid_calc[AW-1:0];
      end
      ST_SHIFT: begin
        // read entry rd_addr while writing the previous read one slot up
        raddr = rd_addr;
        we    = pend;
        waddr = wr_addr;
        wdata = rdata;
      end
      ST_PUT: begin
        we    = 1'b1;
        waddr = lo[AW-1:0];
        wdata = {cur_key, cur_payload};
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PUT) count <= count + 1'b1;
      if (state == ST_SHIFT) pend <= (move_left != '0);
      else                   pend <= 1'b0;
      if (state == ST_RESP && out_free) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur_kind    <= req.kind;
        cur_key     <= req.key[KW-1:0];
        cur_payload <= req.payload[PW-1:0];
        lo          <= '0;
        hi          <= count;
      end
      ST_SEARCH: begin
        mid <= mid_calc[AW-1:0];
        if (search_done) begin
          res_found   <= 1'b0;
          res_payload <= '0;
          if (cur_kind == KIND_LOOKUP) res_status <= STAT_NOT_FOUND;
          else if (count == DEPTH_C)   res_status <= STAT_FULL;
          else                         res_status <= STAT_INSERTED;
          // shift setup; lo now holds the insert position
          move_left <= count - lo;
          rd_addr   <= count_m1[AW-1:0];
        end
      end
      ST_CMP: begin
        if (cur_key == rd_key) begin
          if (cur_kind == KIND_LOOKUP) begin
            res_status  <= STAT_FOUND;
            res_found   <= 1'b1;
            res_payload <= rd_payload;
          end else begin
            res_status  <= STAT_DUPLICATE;
            res_found   <= 1'b0;
            res_payload <= '0;
          end
        end else if (cur_key < rd_key) begin
          hi <= {1'b0, mid};
        end else begin
          lo <= {1'b0, mid} + 1'b1;
        end
      end
      ST_SHIFT: begin
        if (move_left != '0) begin
          wr_addr   <= rd_addr + 1'b1;
          rd_addr   <= rd_addr - 1'b1;
          move_left <= move_left - 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          rsp.status       <= res_status;
          rsp.found        <= res_found;
          rsp.read_payload <= res_payload_ext;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above table depth");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> {1'b0, mid} < count)
    else $error("search probe outside filled entries");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> {1'b0, waddr} <= count && count < DEPTH_C)
    else $error("table write beyond filled region or into full table");

  a_put_counts: assert property (@(posedge clk) disable iff (rst)
    state == ST_PUT |=> count == $past(count) + 1'b1)
    else $error("insert did not bump entry count");

  a_shift_to_put: assert property (@(posedge clk) disable iff (rst)
    state == ST_PUT |-> $past(state) == ST_SHIFT && !pend)
    else $error("record stored before shift drained");
`endif

endmodule
